@@ src/tga_pixel_stream_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// tga pixel stream decoder assertion macros
// Shared assertion wrappers; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef TGA_PIXEL_STREAM_DECODER_TOP_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TPSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPSD_ASSERT_IMP(lbl, ante, cons, msg)
`define TPSD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/tpsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_pkg
// Types, register indexes, status codes and format decode for the decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 32;

    localparam logic [CfgAddrW-1:0] REG_IMAGE_TYPE  = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_PIXEL_DEPTH = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_PIXEL_COUNT = 2'd2;

    localparam logic [7:0] TYPE_RAW  = 8'd2;
    localparam logic [7:0] TYPE_GREY = 8'd3;
    localparam logic [7:0] TYPE_RLE  = 8'd10;

    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OVERFLOW    = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [7:0] RUN_FLAG    = 8'h80;
    localparam logic [7:0] RUN_BIAS    = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [4:0] FIELD_MASK  = 5'h1F;

    typedef struct packed {
        logic [7:0]  image_type;
        logic [7:0]  pixel_depth;
        logic [31:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic       end_of_image;
        logic [7:0] run_length;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } res_t;

    typedef struct packed {
        logic res_valid;
        logic halted;
    } core_stat_t;

    // bytes per pixel, 0 for an unsupported type and depth pair
    function automatic logic [2:0] bytes_per_pixel(input logic [7:0] itype,
                                                   input logic [7:0] depth);
        logic [2:0] n;
        n = 3'd0;
        if (itype == TYPE_GREY)
        begin
            n = 3'd1;
        end
        else if (itype == TYPE_RAW)
        begin
            if (depth == DEPTH_16)
                n = 3'd2;
            else if (depth == DEPTH_24)
                n = 3'd3;
            else if (depth == DEPTH_32)
                n = 3'd4;
        end
        else if (itype == TYPE_RLE)
        begin
            if (depth == DEPTH_24)
                n = 3'd3;
            else if (depth == DEPTH_32)
                n = 3'd4;
        end
        return n;
    endfunction

endpackage

@@ src/tpsd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_core
// Decoder state and per-byte decode: packet parsing, pixel assembly, tally.
// ----------------------------------------------------------------------------
module tpsd_core
    import tpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output res_t       res,
    output core_stat_t stat
);

    logic        expect_hdr_reg,   expect_hdr_next;
    logic        is_run_reg,       is_run_next;
    logic [7:0]  remaining_reg,    remaining_next;
    logic [1:0]  bip_reg,          bip_next;
    logic [23:0] partial_reg,      partial_next;
    logic [31:0] pixels_done_reg,  pixels_done_next;
    logic        halted_reg,       halted_next;

    logic [2:0]  bpp;
    logic        all_done;
    logic [7:0]  left8;
    logic        pix_done;
    logic [23:0] partial_or;
    logic [15:0] word16;
    logic [7:0]  px_b, px_g, px_r, px_a;
    logic [32:0] sum_run;
    logic        run_over;
    logic [31:0] inc_one;
    logic        res_valid;

    always_comb
    begin
        bpp      = bytes_per_pixel(cfg.image_type, cfg.pixel_depth);
        all_done = pixels_done_reg >= cfg.pixel_count;
        // only the low byte matters: a clipped run is shorter than 128
        left8    = all_done ? 8'd0 : (cfg.pixel_count[7:0] - pixels_done_reg[7:0]);
        pix_done = ({1'b0, bip_reg} + 3'd1) >= bpp;

        case (bip_reg)
            2'd0:    partial_or = partial_reg | {16'd0, data_byte};
            2'd1:    partial_or = partial_reg | {8'd0, data_byte, 8'd0};
            2'd2:    partial_or = partial_reg | {data_byte, 16'd0};
            default: partial_or = partial_reg;
        endcase

        word16 = {data_byte, partial_reg[7:0]};
        case (bpp)
            3'd1:
            begin
                px_b = data_byte;
                px_g = data_byte;
                px_r = data_byte;
                px_a = data_byte;
            end
            3'd2:
            begin
                px_b = {word16[4:0] & FIELD_MASK, 3'd0};
                px_g = {word16[9:5] & FIELD_MASK, 3'd0};
                px_r = {word16[14:10] & FIELD_MASK, 3'd0};
                px_a = 8'd0;
            end
            3'd3:
            begin
                px_b = partial_reg[7:0];
                px_g = partial_reg[15:8];
                px_r = data_byte;
                px_a = ALPHA_OPAQUE;
            end
            default:
            begin
                px_b = partial_reg[7:0];
                px_g = partial_reg[15:8];
                px_r = partial_reg[23:16];
                px_a = data_byte;
            end
        endcase

        sum_run  = {1'b0, pixels_done_reg} + {25'd0, remaining_reg};
        run_over = all_done ? (remaining_reg != 8'd0)
                            : (sum_run > {1'b0, cfg.pixel_count});
        inc_one  = pixels_done_reg + 32'd1;
    end

    always_comb
    begin
        expect_hdr_next  = expect_hdr_reg;
        is_run_next      = is_run_reg;
        remaining_next   = remaining_reg;
        bip_next         = bip_reg;
        partial_next     = partial_reg;
        pixels_done_next = pixels_done_reg;
        halted_next      = halted_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (accept && !halted_reg)
        begin
            if (bpp == 3'd0)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res.status  = ST_UNSUPPORTED;
            end
            else if (cfg.image_type == TYPE_RLE && expect_hdr_reg)
            begin
                if (!all_done)
                begin
                    is_run_next     = data_byte >= RUN_FLAG;
                    remaining_next  = (data_byte >= RUN_FLAG) ? (data_byte - RUN_BIAS)
                                                              : (data_byte + 8'd1);
                    expect_hdr_next = 1'b0;
                    bip_next        = 2'd0;
                    partial_next    = 24'd0;
                end
            end
            else if (cfg.image_type == TYPE_RLE || !all_done)
            begin
                if (!pix_done)
                begin
                    partial_next = partial_or;
                    bip_next     = bip_reg + 2'd1;
                end
                else
                begin
                    partial_next = 24'd0;
                    bip_next     = 2'd0;
                    res_valid    = 1'b1;
                    res.blue     = px_b;
                    res.green    = px_g;
                    res.red      = px_r;
                    res.alpha    = px_a;
                    if (cfg.image_type == TYPE_RLE && is_run_reg)
                    begin
                        remaining_next  = 8'd0;
                        expect_hdr_next = 1'b1;
                        if (run_over)
                        begin
                            halted_next      = 1'b1;
                            res.run_length   = left8;
                            res.end_of_image = 1'b1;
                            res.status       = ST_OVERFLOW;
                        end
                        else
                        begin
                            pixels_done_next = sum_run[31:0];
                            res.run_length   = remaining_reg;
                            res.end_of_image = sum_run[31:0] == cfg.pixel_count;
                        end
                    end
                    else if (cfg.image_type == TYPE_RLE && all_done)
                    begin
                        // raw packet pixel beyond the image
                        halted_next = 1'b1;
                        res         = '0;
                        res.status  = ST_OVERFLOW;
                    end
                    else
                    begin
                        pixels_done_next = inc_one;
                        res.run_length   = 8'd1;
                        res.end_of_image = inc_one == cfg.pixel_count;
                        if (cfg.image_type == TYPE_RLE)
                        begin
                            remaining_next = remaining_reg - 8'd1;
                            if (remaining_reg == 8'd1)
                                expect_hdr_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_hdr_reg  <= 1'b1;
            is_run_reg      <= 1'b0;
            remaining_reg   <= 8'd0;
            bip_reg         <= 2'd0;
            partial_reg     <= 24'd0;
            pixels_done_reg <= 32'd0;
            halted_reg      <= 1'b0;
        end
        else
        begin
            expect_hdr_reg  <= expect_hdr_next;
            is_run_reg      <= is_run_next;
            remaining_reg   <= remaining_next;
            bip_reg         <= bip_next;
            partial_reg     <= partial_next;
            pixels_done_reg <= pixels_done_next;
            halted_reg      <= halted_next;
        end
    end

    assign stat.res_valid = res_valid;
    assign stat.halted    = halted_reg;

endmodule

@@ src/tga_pixel_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// Decodes the pixel-data bytes of a TGA image into BGRA pixel words.
// ----------------------------------------------------------------------------
// usage
//   s_*: one pixel-data byte per word, taken when s_tvalid and s_tready are high.
//   m_*: one decoded pixel per word; tlast marks the word that completes the
//        image, tuser carries the status (ok, overflow, unsupported format).
//   cfg_*: image type, pixel depth and pixel count, written while idle.
// timing
//   one byte per cycle while s_tready is high; the byte that completes a
//   result registers it into the buffer. All decode runs between the decoder
//   state registers and a two-word output buffer (output register plus skid).
// stall
//   with m_tready low the buffer absorbs one more word, then s_tready drops
//   until the receiver takes a word.
// reset
//   rst_n clears the decoder state, empties the buffer and restores the
//   registers to type 2, depth 24, count 0. An error halts the block until
//   reset; bytes are then taken and dropped.
// ----------------------------------------------------------------------------
`include "tga_pixel_stream_decoder_top_defines.svh"

module tga_pixel_stream_decoder_top
    import tpsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // blue, green, red, alpha, run_length
    output logic                m_tlast,   // end_of_image
    output logic [1:0]          m_tuser    // status
);

    cfg_t       cfg_reg;
    res_t       core_res;
    core_stat_t core_stat;
    res_t       out_reg;
    res_t       skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       s_accept;
    logic       pop;
    logic       push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_type  <= TYPE_RAW;
            cfg_reg.pixel_depth <= DEPTH_24;
            cfg_reg.pixel_count <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_TYPE:  cfg_reg.image_type  <= cfg_wdata[7:0];
                REG_PIXEL_DEPTH: cfg_reg.pixel_depth <= cfg_wdata[7:0];
                REG_PIXEL_COUNT: cfg_reg.pixel_count <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    tpsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (s_accept),
        .data_byte (s_tdata),
        .res       (core_res),
        .stat      (core_stat)
    );

    assign pop  = out_valid_reg && m_tready;
    assign push = core_stat.res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= core_res;
            else
                skid_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.run_length, out_reg.alpha, out_reg.red,
                       out_reg.green, out_reg.blue};
    assign m_tlast  = out_reg.end_of_image;
    assign m_tuser  = out_reg.status;

    // halt is sticky until reset
    `TPSD_ASSERT_NXT(a_halt_sticky, core_stat.halted, core_stat.halted,
                     "decoder left the halted state")
    // a halted decoder produces nothing
    `TPSD_ASSERT_IMP(a_halt_silent, core_stat.halted, !core_stat.res_valid,
                     "result produced while halted")
    // the skid word only exists behind a held output word
    `TPSD_ASSERT_IMP(a_skid_order, skid_valid_reg, out_valid_reg && !$past(m_tready),
                     "skid word without a stalled output word")
    // a word on the output is never dropped while stalled
    `TPSD_ASSERT_NXT(a_out_hold, out_valid_reg && !m_tready, out_valid_reg,
                     "output word lost during stall")

endmodule
